>>> rtl/swp_pkg.sv
// Shared types and constants for the series win probability block.
package swp_pkg;

  localparam int MAX_WINS_DEF  = 63;
  localparam int PROB_BITS_DEF = 16;
  localparam int WINS_W        = 6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_PUSH
  } state_t;

endpackage

>>> rtl/series_win_probability_dp.sv
// Series win probability: one table row in memory, one cell per cycle through a 2-stage pipe
// while a row issues. Every row issues n memory reads for n wins (n >= 1), then waits for the
// read-multiply-add pipe to drain before the next row starts. A request with zero wins
// goes straight to the output, flagged as bad. One request is in work at a time; a new
// input word is taken while the previous result still waits on the output register.
// Reset (rst, synchronous, active high) clears all control state; the row memory is not cleared.
module series_win_probability_dp #(
  parameter int MAX_WINS  = swp_pkg::MAX_WINS_DEF,
  parameter int PROB_BITS = swp_pkg::PROB_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // wins_needed [5:0], win_prob [PROB_BITS+6:6], zero fill
  input  logic [((swp_pkg::WINS_W + PROB_BITS + 1 + 7) / 8) * 8 - 1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // series_prob [PROB_BITS:0], zero fill
  output logic [((PROB_BITS + 1 + 7) / 8) * 8 - 1:0] m_tdata,
  // bad_request [0]
  output logic m_tuser
);

  localparam int PW     = PROB_BITS + 1;
  localparam int CW     = $clog2(MAX_WINS + 1);
  localparam int DEPTH  = MAX_WINS + 1;
  localparam int OUT_W  = ((PROB_BITS + 1 + 7) / 8) * 8;
  localparam logic [PW-1:0] Q_ONE = PW'(1) << PROB_BITS;

  swp_pkg::state_t state, state_next;

  logic [swp_pkg::WINS_W-1:0] wins_needed;
  logic [PW-1:0]              win_prob;

  logic [CW-1:0] n_sat;
  logic [PW-1:0] p_sat;

  logic [CW-1:0] wins;
  logic [PW-1:0] prob_p;
  logic [PW-1:0] prob_q;
  logic [CW-1:0] row;
  logic [CW-1:0] col;

  logic [PW-1:0] row_mem [DEPTH];
  logic [PW-1:0] rd_data;

  // Stage 1: memory read data valid. Stage 2: above*p product valid.
  logic          v1, v2;
  logic [CW-1:0] col1, col2;
  logic          first1, first2;
  logic          last1, last2;
  logic [PW-1:0] prod_p;

  logic [PW-1:0]     left_value;
  logic [PW-1:0]     above;
  logic [2*PW-1:0]   mul_p;
  logic [PW-1:0]     left_in;
  logic [2*PW-1:0]   mul_q;
  logic [PW:0]       cell_sum;
  logic [PW-1:0]     cell_val;

  logic [PW-1:0] res_prob;
  logic          res_bad;
  logic [PW-1:0] out_prob;
  logic          out_bad;
  logic          out_valid;
  logic          out_load;
  logic          in_fire;
  logic          issue;

  assign wins_needed = s_tdata[swp_pkg::WINS_W-1:0];
  assign win_prob    = s_tdata[swp_pkg::WINS_W +: PW];

  assign s_tready = (state == swp_pkg::ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign issue    = (state == swp_pkg::ST_RUN);
  assign out_load = (state == swp_pkg::ST_PUSH) && (!out_valid || m_tready);

  always_comb begin
    if (int'(wins_needed) > MAX_WINS) begin
      n_sat = CW'(MAX_WINS);
    end else begin
      n_sat = CW'(wins_needed);
    end
    if (win_prob > Q_ONE) begin
      p_sat = Q_ONE;
    end else begin
      p_sat = win_prob;
    end
  end

  // The first row reads as 1.0 everywhere, so the memory is not preloaded.
  assign above    = (row == CW'(1)) ? Q_ONE : rd_data;
  assign mul_p    = (2*PW)'(above) * (2*PW)'(prob_p);
  assign left_in  = first2 ? '0 : left_value;
  assign mul_q    = (2*PW)'(left_in) * (2*PW)'(prob_q);
  assign cell_sum = (PW+1)'(prod_p) + (PW+1)'(mul_q[PROB_BITS +: PW]);
  assign cell_val = cell_sum[PW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      swp_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_next = (wins_needed == '0) ? swp_pkg::ST_PUSH : swp_pkg::ST_RUN;
        end
      end
      swp_pkg::ST_RUN: begin
        if (col == wins) begin
          state_next = swp_pkg::ST_DRAIN;
        end
      end
      swp_pkg::ST_DRAIN: begin
        if (!v1 && !v2) begin
          state_next = (row == wins) ? swp_pkg::ST_PUSH : swp_pkg::ST_RUN;
        end
      end
      swp_pkg::ST_PUSH: begin
        if (out_load) begin
          state_next = swp_pkg::ST_IDLE;
        end
      end
      default: state_next = swp_pkg::ST_IDLE;
    endcase
  end

  // Sequencer counters and request registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      row     <= '0;
      col     <= '0;
      res_bad <= 1'b0;
    end else begin
      if (in_fire) begin
        wins    <= n_sat;
        prob_p  <= p_sat;
        prob_q  <= Q_ONE - p_sat;
        row     <= CW'(1);
        col     <= CW'(1);
        res_bad <= (wins_needed == '0);
      end else if (issue && col != wins) begin
        col <= col + CW'(1);
      end else if (state == swp_pkg::ST_DRAIN && !v1 && !v2 && row != wins) begin
        row <= row + CW'(1);
        col <= CW'(1);
      end
    end
  end

  // Pipeline valid bits and left neighbor.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      left_value <= '0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      if (v2) begin
        left_value <= cell_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= row_mem[col];
    end
    if (v2) begin
      row_mem[col2] <= cell_val;
    end
  end

  always_ff @(posedge clk) begin
    col1   <= col;
    first1 <= (col == CW'(1));
    last1  <= (col == wins);
    col2   <= col1;
    first2 <= first1;
    last2  <= last1;
    prod_p <= mul_p[PROB_BITS +: PW];
    if (in_fire) begin
      res_prob <= '0;
    end else if (v2 && last2 && row == wins) begin
      res_prob <= cell_val;
    end
  end

  // Output register: holds a finished word while the next request is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_prob <= res_prob;
      out_bad  <= res_bad;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_W'(out_prob);
  assign m_tuser  = out_bad;

endmodule

>>> rtl/swp_checker.sv
// Port-level checker for the series win probability block, with its bind.
module swp_checker #(
  parameter int PROB_BITS = swp_pkg::PROB_BITS_DEF
) (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic [((swp_pkg::WINS_W + PROB_BITS + 1 + 7) / 8) * 8 - 1:0] s_tdata,
  input logic m_tvalid,
  input logic m_tready,
  input logic [((PROB_BITS + 1 + 7) / 8) * 8 - 1:0] m_tdata,
  input logic m_tuser
);

  localparam int OUT_W = ((PROB_BITS + 1 + 7) / 8) * 8;
  localparam logic [OUT_W-1:0] Q_ONE = OUT_W'(1) << PROB_BITS;

  // A word waiting on the output must not vanish.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output word dropped while stalled");

  // The block works on one request at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a request is in work");

  // A zero win count taken while the output is free is answered through the push state and the output register.
  a_bad_fast: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tdata[swp_pkg::WINS_W-1:0] == '0 && !m_tvalid
    |-> ##2 (m_tvalid && m_tuser && m_tdata == '0))
    else $error("bad request not answered");

  // A flagged result carries zero probability.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("bad request with nonzero probability");

  // A probability never exceeds one.
  a_prob_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata <= Q_ONE)
    else $error("probability above one");

endmodule

bind series_win_probability_dp swp_checker #(.PROB_BITS(PROB_BITS)) u_swp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
